### rtl/sfoc_pkg.sv
// Shared types and constants for the state feedback observer controller.
// Holds the channel payloads, the coefficient set, and the controller-to-datapath
// command and status structs. No dependencies.
package sfoc_pkg;

   // 2*pi/15 in signed Q8.24
   localparam logic signed [31:0] ANGLE_STEP = 32'sd7027624;
   // half of one Q16.16 step after the Q8.24 product shift
   localparam logic signed [63:0] ROUND_HALF = 64'sd8388608;

   typedef struct packed {
      logic signed [15:0] measured_count;
      logic signed [31:0] setpoint;
   } req_type;

   typedef struct packed {
      logic signed [31:0] control_value;
      logic signed [31:0] speed_estimate;
      logic signed [31:0] angle_estimate;
   } rsp_type;

   typedef enum logic [2:0] {
      CSR_INTEGRAL_GAIN,
      CSR_FEEDBACK_GAIN,
      CSR_INPUT_VECTOR,
      CSR_TRANSITION_ONE,
      CSR_TRANSITION_TWO,
      CSR_OBSERVER_GAIN,
      CSR_SPEED_OUTPUT,
      CSR_ANGLE_OUTPUT
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] ki;
      logic signed [31:0] k1;
      logic signed [31:0] k2;
      logic signed [31:0] h1;
      logic signed [31:0] h2;
      logic signed [31:0] g11;
      logic signed [31:0] g12;
      logic signed [31:0] g21;
      logic signed [31:0] g22;
      logic signed [31:0] l1;
      logic signed [31:0] l2;
      logic signed [31:0] cs1;
      logic signed [31:0] cs2;
      logic signed [31:0] ca1;
      logic signed [31:0] ca2;
   } coef_set_type;

   typedef enum logic [2:0] {
      VAL_CNT,
      VAL_ESUM,
      VAL_S1,
      VAL_S2,
      VAL_U,
      VAL_DIFF,
      VAL_X1,
      VAL_X2
   } val_sel_type;

   typedef enum logic [3:0] {
      COEF_ANG,
      COEF_KI,
      COEF_K1,
      COEF_K2,
      COEF_H1,
      COEF_H2,
      COEF_G11,
      COEF_G12,
      COEF_G21,
      COEF_G22,
      COEF_L1,
      COEF_L2,
      COEF_CS1,
      COEF_CS2,
      COEF_CA1,
      COEF_CA2
   } coef_sel_type;

   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_LOAD,
      ACC_ADD,
      ACC_ERR,
      ACC_ESUM,
      ACC_INNOV
   } acc_op_type;

   typedef enum logic [3:0] {
      WR_NONE,
      WR_ERR,
      WR_ANGLE,
      WR_DIFF,
      WR_ESUM,
      WR_U,
      WR_X1,
      WR_X2,
      WR_SPD,
      WR_AEST
   } wr_sel_type;

   typedef struct packed {
      logic         load_in;
      val_sel_type  val_sel;
      coef_sel_type coef_sel;
      acc_op_type   acc_op;
      wr_sel_type   wr_sel;
      logic         commit;
      logic         load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dp_status_type;

endpackage

### rtl/sfoc_csr.sv
// Coefficient register file of the state feedback observer controller.
// Decodes plain writes into the coefficient set; uses sfoc_pkg.
module sfoc_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [63:0]           csr_wdata,
   output sfoc_pkg::coef_set_type coef
);

   logic [31:0] ki_ff;
   logic [63:0] fb_ff;
   logic [63:0] iv_ff;
   logic [63:0] tr1_ff;
   logic [63:0] tr2_ff;
   logic [63:0] obs_ff;
   logic [63:0] spd_ff;
   logic [63:0] ang_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ki_ff  <= '0;
         fb_ff  <= '0;
         iv_ff  <= '0;
         tr1_ff <= '0;
         tr2_ff <= '0;
         obs_ff <= '0;
         spd_ff <= '0;
         ang_ff <= '0;
      end else if (csr_we) begin
         unique case (sfoc_pkg::csr_index_type'(csr_index))
            sfoc_pkg::CSR_INTEGRAL_GAIN:  ki_ff  <= csr_wdata[31:0];
            sfoc_pkg::CSR_FEEDBACK_GAIN:  fb_ff  <= csr_wdata;
            sfoc_pkg::CSR_INPUT_VECTOR:   iv_ff  <= csr_wdata;
            sfoc_pkg::CSR_TRANSITION_ONE: tr1_ff <= csr_wdata;
            sfoc_pkg::CSR_TRANSITION_TWO: tr2_ff <= csr_wdata;
            sfoc_pkg::CSR_OBSERVER_GAIN:  obs_ff <= csr_wdata;
            sfoc_pkg::CSR_SPEED_OUTPUT:   spd_ff <= csr_wdata;
            sfoc_pkg::CSR_ANGLE_OUTPUT:   ang_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // upper half of each pair goes with state one / column one
   assign coef.ki  = ki_ff;
   assign coef.k1  = fb_ff[63:32];
   assign coef.k2  = fb_ff[31:0];
   assign coef.h1  = iv_ff[63:32];
   assign coef.h2  = iv_ff[31:0];
   assign coef.g11 = tr1_ff[63:32];
   assign coef.g12 = tr1_ff[31:0];
   assign coef.g21 = tr2_ff[63:32];
   assign coef.g22 = tr2_ff[31:0];
   assign coef.l1  = obs_ff[63:32];
   assign coef.l2  = obs_ff[31:0];
   assign coef.cs1 = spd_ff[63:32];
   assign coef.cs2 = spd_ff[31:0];
   assign coef.ca1 = ang_ff[63:32];
   assign coef.ca2 = ang_ff[31:0];

endmodule

### rtl/sfoc_ctrl.sv
// Sequencer of the state feedback observer controller.
// Steps the shared multiply-accumulate datapath through one sample; uses sfoc_pkg.
module sfoc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  sfoc_pkg::dp_status_type status,
   output sfoc_pkg::dp_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   localparam logic [4:0] STEP_LAST = 5'd27;

   state_type   state_ff, state_in;
   logic [4:0]  step_ff, step_in;

   function automatic sfoc_pkg::dp_cmd_type nop_cmd();
      sfoc_pkg::dp_cmd_type c;
      c.load_in  = 1'b0;
      c.val_sel  = sfoc_pkg::VAL_CNT;
      c.coef_sel = sfoc_pkg::COEF_ANG;
      c.acc_op   = sfoc_pkg::ACC_NONE;
      c.wr_sel   = sfoc_pkg::WR_NONE;
      c.commit   = 1'b0;
      c.load_out = 1'b0;
      return c;
   endfunction

   // Product issued in a step lands in the product register; the next step
   // accumulates it, and the step after that can store the saturated sum.
   function automatic sfoc_pkg::dp_cmd_type step_cmd(input logic [4:0] step);
      sfoc_pkg::dp_cmd_type c;
      c = nop_cmd();
      unique case (step)
         5'd0: c.acc_op = sfoc_pkg::ACC_ERR;
         5'd1: begin
            c.wr_sel   = sfoc_pkg::WR_ERR;
            c.val_sel  = sfoc_pkg::VAL_CNT;
            c.coef_sel = sfoc_pkg::COEF_ANG;
         end
         5'd2: c.acc_op = sfoc_pkg::ACC_LOAD;
         5'd3: c.wr_sel = sfoc_pkg::WR_ANGLE;
         5'd4: c.acc_op = sfoc_pkg::ACC_INNOV;
         5'd5: begin
            c.wr_sel = sfoc_pkg::WR_DIFF;
            c.acc_op = sfoc_pkg::ACC_ESUM;
         end
         5'd6: c.wr_sel = sfoc_pkg::WR_ESUM;
         5'd7: begin
            c.val_sel  = sfoc_pkg::VAL_ESUM;
            c.coef_sel = sfoc_pkg::COEF_KI;
         end
         5'd8: begin
            c.val_sel  = sfoc_pkg::VAL_S1;
            c.coef_sel = sfoc_pkg::COEF_K1;
            c.acc_op   = sfoc_pkg::ACC_LOAD;
         end
         5'd9: begin
            c.val_sel  = sfoc_pkg::VAL_S2;
            c.coef_sel = sfoc_pkg::COEF_K2;
            c.acc_op   = sfoc_pkg::ACC_ADD;
         end
         5'd10: c.acc_op = sfoc_pkg::ACC_ADD;
         5'd11: c.wr_sel = sfoc_pkg::WR_U;
         5'd12: begin
            c.val_sel  = sfoc_pkg::VAL_U;
            c.coef_sel = sfoc_pkg::COEF_H1;
         end
         5'd13: begin
            c.val_sel  = sfoc_pkg::VAL_S1;
            c.coef_sel = sfoc_pkg::COEF_G11;
            c.acc_op   = sfoc_pkg::ACC_LOAD;
         end
         5'd14: begin
            c.val_sel  = sfoc_pkg::VAL_S2;
            c.coef_sel = sfoc_pkg::COEF_G12;
            c.acc_op   = sfoc_pkg::ACC_ADD;
         end
         5'd15: begin
            c.val_sel  = sfoc_pkg::VAL_DIFF;
            c.coef_sel = sfoc_pkg::COEF_L1;
            c.acc_op   = sfoc_pkg::ACC_ADD;
         end
         5'd16: begin
            c.val_sel  = sfoc_pkg::VAL_U;
            c.coef_sel = sfoc_pkg::COEF_H2;
            c.acc_op   = sfoc_pkg::ACC_ADD;
         end
         5'd17: begin
            c.val_sel  = sfoc_pkg::VAL_S1;
            c.coef_sel = sfoc_pkg::COEF_G21;
            c.acc_op   = sfoc_pkg::ACC_LOAD;
            c.wr_sel   = sfoc_pkg::WR_X1;
         end
         5'd18: begin
            c.val_sel  = sfoc_pkg::VAL_S2;
            c.coef_sel = sfoc_pkg::COEF_G22;
            c.acc_op   = sfoc_pkg::ACC_ADD;
         end
         5'd19: begin
            c.val_sel  = sfoc_pkg::VAL_DIFF;
            c.coef_sel = sfoc_pkg::COEF_L2;
            c.acc_op   = sfoc_pkg::ACC_ADD;
         end
         5'd20: c.acc_op = sfoc_pkg::ACC_ADD;
         5'd21: c.wr_sel = sfoc_pkg::WR_X2;
         5'd22: begin
            c.val_sel  = sfoc_pkg::VAL_X1;
            c.coef_sel = sfoc_pkg::COEF_CS1;
         end
         5'd23: begin
            c.val_sel  = sfoc_pkg::VAL_X2;
            c.coef_sel = sfoc_pkg::COEF_CS2;
            c.acc_op   = sfoc_pkg::ACC_LOAD;
         end
         5'd24: begin
            c.val_sel  = sfoc_pkg::VAL_X1;
            c.coef_sel = sfoc_pkg::COEF_CA1;
            c.acc_op   = sfoc_pkg::ACC_ADD;
         end
         5'd25: begin
            c.val_sel  = sfoc_pkg::VAL_X2;
            c.coef_sel = sfoc_pkg::COEF_CA2;
            c.acc_op   = sfoc_pkg::ACC_LOAD;
            c.wr_sel   = sfoc_pkg::WR_SPD;
         end
         5'd26: c.acc_op = sfoc_pkg::ACC_ADD;
         5'd27: begin
            c.wr_sel = sfoc_pkg::WR_AEST;
            c.commit = 1'b1;
         end
         default: ;
      endcase
      return c;
   endfunction

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = nop_cmd();
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_RUN;
               step_in     = '0;
            end
         end
         ST_RUN: begin
            cmd = step_cmd(step_ff);
            if (step_ff == STEP_LAST) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         ST_DONE: begin
            // hold until the result register is free
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

### rtl/sfoc_dp.sv
// Datapath of the state feedback observer controller: one shared 32x32
// multiplier, a rounding accumulator with saturation, state and result registers.
// Driven by sfoc_ctrl commands; uses sfoc_pkg.
module sfoc_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  sfoc_pkg::dp_cmd_type    cmd,
   input  sfoc_pkg::coef_set_type  coef,
   input  sfoc_pkg::req_type       req_data,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output sfoc_pkg::rsp_type       rsp_data,
   output sfoc_pkg::dp_status_type status
);

   localparam logic signed [43:0] SAT_MAX = 44'sd2147483647;
   localparam logic signed [43:0] SAT_MIN = -44'sd2147483648;

   logic signed [15:0] cnt_ff;
   logic signed [31:0] sp_ff;
   logic signed [31:0] err_ff;
   logic signed [31:0] angle_ff;
   logic signed [31:0] diff_ff;
   logic signed [31:0] esum_ff;
   logic signed [31:0] u_ff;
   logic signed [31:0] x1_ff;
   logic signed [31:0] x2_ff;
   logic signed [31:0] s1_ff;
   logic signed [31:0] s2_ff;
   logic signed [31:0] spd_ff;
   logic signed [31:0] aest_ff;
   logic signed [63:0] p_ff;
   logic signed [43:0] acc_ff, acc_in;
   sfoc_pkg::rsp_type  rsp_ff;
   logic               rsp_valid_ff;

   logic signed [31:0] val_mux;
   logic signed [31:0] coef_mux;
   logic signed [63:0] prod;
   logic signed [63:0] rnd;
   logic signed [39:0] term;
   logic signed [31:0] acc_sat;

   function automatic logic signed [43:0] sx44(input logic [31:0] v);
      return $signed({{12{v[31]}}, v});
   endfunction

   always_comb begin
      case (cmd.val_sel)
         sfoc_pkg::VAL_CNT:  val_mux = {cnt_ff, 16'h0000};
         sfoc_pkg::VAL_ESUM: val_mux = esum_ff;
         sfoc_pkg::VAL_S1:   val_mux = s1_ff;
         sfoc_pkg::VAL_S2:   val_mux = s2_ff;
         sfoc_pkg::VAL_U:    val_mux = u_ff;
         sfoc_pkg::VAL_DIFF: val_mux = diff_ff;
         sfoc_pkg::VAL_X1:   val_mux = x1_ff;
         sfoc_pkg::VAL_X2:   val_mux = x2_ff;
         default:            val_mux = '0;
      endcase
   end

   always_comb begin
      case (cmd.coef_sel)
         sfoc_pkg::COEF_ANG: coef_mux = sfoc_pkg::ANGLE_STEP;
         sfoc_pkg::COEF_KI:  coef_mux = coef.ki;
         sfoc_pkg::COEF_K1:  coef_mux = coef.k1;
         sfoc_pkg::COEF_K2:  coef_mux = coef.k2;
         sfoc_pkg::COEF_H1:  coef_mux = coef.h1;
         sfoc_pkg::COEF_H2:  coef_mux = coef.h2;
         sfoc_pkg::COEF_G11: coef_mux = coef.g11;
         sfoc_pkg::COEF_G12: coef_mux = coef.g12;
         sfoc_pkg::COEF_G21: coef_mux = coef.g21;
         sfoc_pkg::COEF_G22: coef_mux = coef.g22;
         sfoc_pkg::COEF_L1:  coef_mux = coef.l1;
         sfoc_pkg::COEF_L2:  coef_mux = coef.l2;
         sfoc_pkg::COEF_CS1: coef_mux = coef.cs1;
         sfoc_pkg::COEF_CS2: coef_mux = coef.cs2;
         sfoc_pkg::COEF_CA1: coef_mux = coef.ca1;
         sfoc_pkg::COEF_CA2: coef_mux = coef.ca2;
         default:            coef_mux = '0;
      endcase
   end

   assign prod = val_mux * coef_mux;

   // round half up, then floor shift back to Q16.16
   assign rnd  = p_ff + sfoc_pkg::ROUND_HALF;
   assign term = rnd[63:24];

   always_comb begin
      case (cmd.acc_op)
         sfoc_pkg::ACC_LOAD:  acc_in = {{4{term[39]}}, term};
         sfoc_pkg::ACC_ADD:   acc_in = acc_ff + {{4{term[39]}}, term};
         sfoc_pkg::ACC_ERR:   acc_in = sx44(sp_ff) - sx44(spd_ff);
         sfoc_pkg::ACC_ESUM:  acc_in = sx44(esum_ff) + sx44(err_ff);
         sfoc_pkg::ACC_INNOV: acc_in = sx44(angle_ff) - sx44(aest_ff);
         default:             acc_in = acc_ff;
      endcase
   end

   always_comb begin
      if (acc_ff > SAT_MAX) begin
         acc_sat = 32'sh7fffffff;
      end else if (acc_ff < SAT_MIN) begin
         acc_sat = 32'sh80000000;
      end else begin
         acc_sat = acc_ff[31:0];
      end
   end

   // datapath payload, no reset needed
   always_ff @(posedge clock) begin
      p_ff   <= prod;
      acc_ff <= acc_in;
      if (cmd.load_in) begin
         cnt_ff <= req_data.measured_count;
         sp_ff  <= req_data.setpoint;
      end
      case (cmd.wr_sel)
         sfoc_pkg::WR_ERR:   err_ff   <= acc_sat;
         sfoc_pkg::WR_ANGLE: angle_ff <= acc_sat;
         sfoc_pkg::WR_DIFF:  diff_ff  <= acc_sat;
         sfoc_pkg::WR_U:     u_ff     <= acc_sat;
         sfoc_pkg::WR_X1:    x1_ff    <= acc_sat;
         sfoc_pkg::WR_X2:    x2_ff    <= acc_sat;
         default: ;
      endcase
      if (cmd.load_out) begin
         rsp_ff.control_value  <= u_ff;
         rsp_ff.speed_estimate <= spd_ff;
         rsp_ff.angle_estimate <= aest_ff;
      end
   end

   // loop state carried from sample to sample
   always_ff @(posedge clock) begin
      if (reset) begin
         esum_ff <= '0;
         s1_ff   <= '0;
         s2_ff   <= '0;
         spd_ff  <= '0;
         aest_ff <= '0;
      end else begin
         if (cmd.wr_sel == sfoc_pkg::WR_ESUM) begin
            esum_ff <= acc_sat;
         end
         if (cmd.wr_sel == sfoc_pkg::WR_SPD) begin
            spd_ff <= acc_sat;
         end
         if (cmd.wr_sel == sfoc_pkg::WR_AEST) begin
            aest_ff <= acc_sat;
         end
         if (cmd.commit) begin
            s1_ff <= x1_ff;
            s2_ff <= x2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;
   assign status.out_busy = rsp_valid_ff & rsp_stall;

endmodule

### rtl/state_feedback_observer_controller_top.sv
// A new request beat is accepted only while the sequencer is idle, that is, once the
// previous sample's result has been loaded into the result register; 16 products run
// through a single shared 32x32 multiplier and accumulator, sequenced by a step counter.
// A waiting result beat holds the sequencer only at its final output load.
// Reset (synchronous, active high) clears coefficients, loop state and valid flags.
module state_feedback_observer_controller_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  sfoc_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sfoc_pkg::rsp_type  rsp_data,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   sfoc_pkg::coef_set_type  coef;
   sfoc_pkg::dp_cmd_type    cmd;
   sfoc_pkg::dp_status_type status;

   sfoc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   sfoc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sfoc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .coef      (coef),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .status    (status)
   );

endmodule

### tb/tb.sv
// Self-checking testbench for state_feedback_observer_controller_top.
// Predicts every control and estimate beat from its own fixed-point copy of the
// loop and compares beat by beat. Depends only on sfoc_pkg and the top-level RTL.
module tb;

   localparam int LIMIT_TIME = 2_000_000;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_REPORTS = 10;
   localparam logic signed [31:0] ANGLE_PER_COUNT_Q24 = 32'sd7027624;

   typedef enum int {GAIN_MILD, GAIN_ANY, GAIN_CORNER} gain_kind_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   sfoc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   sfoc_pkg::rsp_type rsp_data;
   logic              csr_we = 1'b0;
   logic [2:0]        csr_index = '0;
   logic [63:0]       csr_wdata = '0;

   // loop copy used for prediction
   logic [63:0]        coef_reg [8];
   logic [63:0]        next_coef [8];
   logic signed [31:0] obs_x1, obs_x2, err_acc, speed_est, angle_est;
   logic signed [31:0] held_setpoint;

   sfoc_pkg::rsp_type pending_beats [$];
   sfoc_pkg::rsp_type want;
   int      failures;
   int      samples_sent;
   int      beats_checked;
   int      settings_used;
   int      send_idle_pct;
   int      stall_pct;

   state_feedback_observer_controller_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic longint q24_product(input logic signed [31:0] val,
                                          input logic signed [31:0] coef);
      longint p;
      p = longint'(val) * longint'(coef) + 64'sd8388608;
      return p >>> 24;
   endfunction

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
      if (v < -longint'(32'sh7FFF_FFFF) - 1) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] upper(input logic [63:0] pair);
      return $signed(pair[63:32]);
   endfunction

   function automatic logic signed [31:0] lower(input logic [63:0] pair);
      return $signed(pair[31:0]);
   endfunction

   function automatic void clear_loop();
      for (int i = 0; i < 8; i++) coef_reg[i] = '0;
      obs_x1 = '0;
      obs_x2 = '0;
      err_acc = '0;
      speed_est = '0;
      angle_est = '0;
   endfunction

   function automatic sfoc_pkg::rsp_type run_controller(input sfoc_pkg::req_type s);
      logic signed [31:0] err, err_total, drive, angle, innov, x1n, x2n;
      logic [63:0]        kfb, hin, row1, row2, lobs, cspd, cang;
      sfoc_pkg::rsp_type  r;
      kfb  = coef_reg[sfoc_pkg::CSR_FEEDBACK_GAIN];
      hin  = coef_reg[sfoc_pkg::CSR_INPUT_VECTOR];
      row1 = coef_reg[sfoc_pkg::CSR_TRANSITION_ONE];
      row2 = coef_reg[sfoc_pkg::CSR_TRANSITION_TWO];
      lobs = coef_reg[sfoc_pkg::CSR_OBSERVER_GAIN];
      cspd = coef_reg[sfoc_pkg::CSR_SPEED_OUTPUT];
      cang = coef_reg[sfoc_pkg::CSR_ANGLE_OUTPUT];

      err = clip32(longint'(s.setpoint) - longint'(speed_est));
      err_total = clip32(longint'(err_acc) + longint'(err));
      drive = clip32(q24_product(err_total, lower(coef_reg[sfoc_pkg::CSR_INTEGRAL_GAIN]))
                     + q24_product(obs_x1, upper(kfb))
                     + q24_product(obs_x2, lower(kfb)));
      err_acc = err_total;

      angle = clip32(q24_product($signed({s.measured_count, 16'h0000}),
                                 ANGLE_PER_COUNT_Q24));
      innov = clip32(longint'(angle) - longint'(angle_est));

      x1n = clip32(q24_product(drive, upper(hin)) + q24_product(obs_x1, upper(row1))
                   + q24_product(obs_x2, lower(row1)) + q24_product(innov, upper(lobs)));
      x2n = clip32(q24_product(drive, lower(hin)) + q24_product(obs_x1, upper(row2))
                   + q24_product(obs_x2, lower(row2)) + q24_product(innov, lower(lobs)));
      obs_x1 = x1n;
      obs_x2 = x2n;
      speed_est = clip32(q24_product(x1n, upper(cspd)) + q24_product(x2n, lower(cspd)));
      angle_est = clip32(q24_product(x1n, upper(cang)) + q24_product(x2n, lower(cang)));

      r.control_value = drive;
      r.speed_estimate = speed_est;
      r.angle_estimate = angle_est;
      return r;
   endfunction

   task automatic note_failure(input string what);
      failures++;
      if (failures <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] got_val);
      if (got_val !== exp_val)
         note_failure($sformatf("beat %0d %s expected %h got %h",
                                beats_checked, name, exp_val, got_val));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            note_failure($sformatf("unexpected result beat %h", rsp_data));
         end else begin
            want = pending_beats.pop_front();
            check_field("control_value", want.control_value, rsp_data.control_value);
            check_field("speed_estimate", want.speed_estimate, rsp_data.speed_estimate);
            check_field("angle_estimate", want.angle_estimate, rsp_data.angle_estimate);
         end
         beats_checked++;
      end
   end

   // hold valid across back-to-back beats; drop it only while idling
   task automatic send_sample(input sfoc_pkg::req_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_beats.push_back(run_controller(s));
      samples_sent++;
   endtask

   task automatic send_pair(input logic [15:0] count, input logic [31:0] speed);
      sfoc_pkg::req_type s;
      s.measured_count = count;
      s.setpoint = speed;
      send_sample(s);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic apply_coefs();
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= next_coef[i];
         @(posedge clock);
         // integral gain is only 32 bits wide
         coef_reg[i] = (i == sfoc_pkg::CSR_INTEGRAL_GAIN) ?
                       {32'h0, next_coef[i][31:0]} : next_coef[i];
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [31:0] make_coef(input gain_kind_type kind);
      case (kind)
         GAIN_MILD: return 32'($urandom_range(32'd16777216)) - 32'd8388608;
         GAIN_ANY:  return $urandom;
         default: begin
            case ($urandom_range(4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'h0000_0001;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   task automatic program_random(input gain_kind_type kind);
      for (int i = 0; i < 8; i++) next_coef[i] = {make_coef(kind), make_coef(kind)};
      // upper word of the integral gain must be ignored
      next_coef[sfoc_pkg::CSR_INTEGRAL_GAIN][63:32] = $urandom;
      apply_coefs();
   endtask

   function automatic sfoc_pkg::req_type make_sample();
      sfoc_pkg::req_type s;
      if ($urandom_range(15) == 0) begin
         case ($urandom_range(3))
            0: held_setpoint = $urandom;
            1, 2: held_setpoint = 32'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
            default: held_setpoint = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         endcase
      end
      if ($urandom_range(3) == 0) s.measured_count = 16'($urandom);
      else s.measured_count = 16'($urandom_range(4000)) - 16'd2000;
      s.setpoint = held_setpoint;
      return s;
   endfunction

   task automatic test_zero_coefficients();
      send_pair(16'h8000, 32'h7FFF_FFFF);
      send_pair(16'h7FFF, 32'h8000_0000);
      send_pair(16'h0000, 32'h0000_0000);
      drain();
   endtask

   task automatic test_plant_response();
      next_coef[sfoc_pkg::CSR_INTEGRAL_GAIN]  = {32'hA5A5_5A5A, 32'd167772};
      next_coef[sfoc_pkg::CSR_FEEDBACK_GAIN]  = {-32'sd8388608, -32'sd4194304};
      next_coef[sfoc_pkg::CSR_INPUT_VECTOR]   = {32'sd167772, 32'sd1677722};
      next_coef[sfoc_pkg::CSR_TRANSITION_ONE] = {32'sd16777216, 32'sd167772};
      next_coef[sfoc_pkg::CSR_TRANSITION_TWO] = {32'sd0, 32'sd15938355};
      next_coef[sfoc_pkg::CSR_OBSERVER_GAIN]  = {32'sd5033165, 32'sd838861};
      next_coef[sfoc_pkg::CSR_SPEED_OUTPUT]   = {32'sd0, 32'sd16777216};
      next_coef[sfoc_pkg::CSR_ANGLE_OUTPUT]   = {32'sd16777216, 32'sd0};
      apply_coefs();
      send_pair(16'd0, 32'h0001_0000);
      send_pair(16'd100, 32'h0001_0000);
      send_pair(16'hFFFF, 32'hFFFF_0000);
      send_pair(16'd1, 32'h7FFF_FFFF);
      // let the pipeline empty before the next beat
      drain();
      // repeated full-scale error drives the integrator into saturation
      send_pair(16'h7FFF, 32'h7FFF_FFFF);
      send_pair(16'h7FFF, 32'h7FFF_FFFF);
      send_pair(16'h8000, 32'h8000_0000);
      send_pair(16'h8000, 32'h8000_0000);
      send_pair(16'h0000, 32'h0000_0000);
      drain();
   endtask

   task automatic test_saturation_corners();
      for (int i = 0; i < 8; i++) next_coef[i] = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
      apply_coefs();
      send_pair(16'h7FFF, 32'h7FFF_FFFF);
      send_pair(16'h8000, 32'h8000_0000);
      send_pair(16'hFFFF, 32'hFFFF_FFFF);
      send_pair(16'h0000, 32'h7FFF_FFFF);
      drain();
      for (int i = 0; i < 8; i++) next_coef[i] = {32'h8000_0000, 32'h7FFF_FFFF};
      next_coef[sfoc_pkg::CSR_INTEGRAL_GAIN] = {32'hFFFF_FFFF, 32'h8000_0000};
      apply_coefs();
      send_pair(16'h8000, 32'h7FFF_FFFF);
      send_pair(16'h7FFF, 32'h8000_0000);
      send_pair(16'h0001, 32'h0000_0001);
      drain();
   endtask

   task automatic test_random_pacing();
      int            idle_by_phase [4] = '{0, 73, 0, 37};
      int            stall_by_phase [4] = '{0, 0, 73, 37};
      gain_kind_type plan [5] = '{GAIN_MILD, GAIN_MILD, GAIN_ANY, GAIN_MILD, GAIN_CORNER};
      held_setpoint = 32'sh0004_0000;
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_by_phase[phase];
         stall_pct = stall_by_phase[phase];
         for (int seg = 0; seg < 5; seg++) begin
            program_random(plan[seg]);
            repeat (70) send_sample(make_sample());
            drain();
         end
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      clear_loop();
      failures = 0;
      samples_sent = 0;
      beats_checked = 0;
      settings_used = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_coefficients();
      test_plant_response();
      test_saturation_corners();
      test_random_pacing();

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_beats.size() != 0)
         note_failure($sformatf("%0d result beats never arrived", pending_beats.size()));
      $display("Run covered %0d samples and %0d result beats under %0d coefficient settings,",
               samples_sent, beats_checked, settings_used);
      $display("with saturating gains and idle or stall rates of up to 73 percent.");
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d failures", failures);
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #LIMIT_TIME;
      $display("timeout with %0d result beats outstanding", pending_beats.size());
      $display("FAILURE");
      $finish;
   end

endmodule

### files.f
rtl/sfoc_pkg.sv
rtl/sfoc_csr.sv
rtl/sfoc_ctrl.sv
rtl/sfoc_dp.sv
rtl/state_feedback_observer_controller_top.sv
tb/tb.sv
